### rtl/core/ffa_pkg.sv
// Package for the fixed frame allocator: field widths, command codes,
// register indexes and the command, response and divider word types.
// No dependencies.
package ffa_pkg;

  localparam int FRAME_SIZE_W   = 16;
  localparam int FIU_W          = 7;
  localparam int REQ_W          = 20;
  localparam int IDX_W          = 6;
  localparam int OWNER_W        = 8;
  localparam int CNT_W          = 7;
  localparam int FRAG_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = FRAME_SIZE_W;

  localparam int NUM_FRAMES_DEF = 64;
  localparam int ID_BITS_DEF    = 8;

  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RST = 16'd256;
  localparam logic [FIU_W-1:0]        FIU_RST        = 7'd64;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_SIZE    = 2'd0,
    REG_FRAMES_IN_USE = 2'd1
  } reg_idx_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [OWNER_W-1:0] owner_id;
    logic [REQ_W-1:0]   request_size;
    logic [IDX_W-1:0]   frame_index;
  } req_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]   frames_changed;
    logic [FRAG_W-1:0]  last_frag;
    logic               shortfall;
    logic               entry_busy;
    logic [OWNER_W-1:0] entry_owner;
    logic [FRAG_W-1:0]  entry_frag;
  } rsp_word_t;

  typedef struct packed {
    logic [REQ_W-1:0]        quot;
    logic [FRAME_SIZE_W-1:0] rem;
  } div_res_t;

endpackage

### rtl/core/ffa_stream_if.sv
// Valid/ready stream channel carrying one word of type T.
// Used with the word types of ffa_pkg.
interface ffa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/ffa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### rtl/core/ffa_div.sv
// Restoring radix-2 divider: request size by frame size, one quotient bit per cycle.
// Depends on ffa_pkg.
module ffa_div import ffa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [REQ_W-1:0]        dividend,
  input  logic [FRAME_SIZE_W-1:0] divisor,
  output logic                    done,
  output div_res_t                res
);
  localparam int STEP_W = $clog2(REQ_W);

  logic                    busy;
  logic [STEP_W-1:0]       step;
  logic [FRAME_SIZE_W-1:0] dvs;
  logic [FRAME_SIZE_W:0]   shifted;
  logic                    fits;

  assign shifted = {res.rem, res.quot[REQ_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        dvs      <= divisor;
        res.quot <= dividend;
        res.rem  <= '0;
      end else if (busy) begin
        res.rem  <= fits ? FRAME_SIZE_W'(shifted - {1'b0, dvs}) : shifted[FRAME_SIZE_W-1:0];
        res.quot <= {res.quot[REQ_W-2:0], fits};
        step     <= step + STEP_W'(1);
        if (step == STEP_W'(REQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/core/fixed_frame_allocator.sv
// Fixed frame allocator: first-fit claim and release over a table of equal frames.
// Allocate divides the request by the frame size, then scans the managed frames; release
// scans them; query reads one entry; no-op and allocate at zero frame size go straight to
// the response. One command at a time, the next can be taken in the same cycle the response
// rises; the per-frame scan through the single table RAM read port sets the rate. Synchronous
// reset clears the table (no command taken) and sets frame size 256, 64 frames in use.
module fixed_frame_allocator import ffa_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ffa_stream_if.sink            req,
  ffa_stream_if.source          rsp,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int AW     = $clog2(NUM_FRAMES);
  localparam int CW     = $clog2(NUM_FRAMES + 1);
  localparam int WORD_W = 1 + ID_BITS + FRAG_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_QUERY,
    S_RESULT
  } state_t;

  state_t                  state;
  logic [FRAME_SIZE_W-1:0] frame_size;
  logic [FIU_W-1:0]        frames_in_use;
  logic [CW-1:0]           lim;

  cmd_t                    cur_cmd;
  logic [ID_BITS-1:0]      own;
  logic [REQ_W-1:0]        full;
  logic                    need_part;
  logic [FRAG_W-1:0]       frag_val;
  logic [FRAG_W-1:0]       last_frag;
  logic [CNT_W-1:0]        changed;
  logic                    q_hit;
  logic                    q_busy;
  logic [OWNER_W-1:0]      q_owner;
  logic [FRAG_W-1:0]       q_frag;

  logic [CW-1:0]           ptr;
  logic                    chk_valid;
  logic [AW-1:0]           chk_addr;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;
  logic                    rd_busy;
  logic [ID_BITS-1:0]      rd_owner;
  logic [FRAG_W-1:0]       rd_frag;

  logic                    claim_full;
  logic                    claim_part;
  logic                    free_hit;

  logic                    div_start;
  logic                    div_done;
  div_res_t                div_res;

  assign lim = (32'(frames_in_use) > NUM_FRAMES) ? CW'(NUM_FRAMES) : CW'(frames_in_use);

  assign req.ready = (state == S_IDLE);

  assign rd_busy  = ram_rdata[WORD_W-1];
  assign rd_owner = ram_rdata[FRAG_W +: ID_BITS];
  assign rd_frag  = ram_rdata[FRAG_W-1:0];

  assign claim_full = (state == S_SCAN) && chk_valid && (cur_cmd == CMD_ALLOC) &&
                      !rd_busy && (full != '0);
  assign claim_part = (state == S_SCAN) && chk_valid && (cur_cmd == CMD_ALLOC) &&
                      !rd_busy && (full == '0) && need_part;
  assign free_hit   = (state == S_SCAN) && chk_valid && (cur_cmd == CMD_RELEASE) &&
                      rd_busy && (rd_owner == own);

  assign div_start = req.valid && req.ready && (req.data.cmd == CMD_ALLOC) &&
                     (frame_size != '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = ptr[AW-1:0];
    end else if (claim_full) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, own, FRAG_W'(0)};
    end else if (claim_part) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, own, frag_val};
    end else if (free_hit) begin
      ram_we    = 1'b1;
    end
    ram_raddr = (state == S_IDLE) ? AW'(req.data.frame_index) : ptr[AW-1:0];
  end

  ffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  ffa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.data.request_size),
    .divisor  (frame_size),
    .done     (div_done),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      ptr           <= '0;
      chk_valid     <= 1'b0;
      rsp.valid     <= 1'b0;
      frame_size    <= FRAME_SIZE_RST;
      frames_in_use <= FIU_RST;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FRAME_SIZE) begin
          frame_size <= cfg_data;
        end else if (cfg_index == REG_FRAMES_IN_USE) begin
          frames_in_use <= cfg_data[FIU_W-1:0];
        end
      end

      if (rsp.valid && rsp.ready && state != S_RESULT) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + CW'(1);
          if (ptr == CW'(NUM_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cur_cmd   <= req.data.cmd;
            own       <= ID_BITS'(req.data.owner_id);
            changed   <= '0;
            last_frag <= '0;
            need_part <= 1'b0;
            q_busy    <= 1'b0;
            q_owner   <= '0;
            q_frag    <= '0;
            q_hit     <= 32'(req.data.frame_index) < NUM_FRAMES;
            full      <= (req.data.cmd == CMD_ALLOC && frame_size == '0) ?
                         req.data.request_size : '0;
            ptr       <= '0;
            chk_valid <= 1'b0;
            unique case (req.data.cmd)
              CMD_ALLOC:   state <= (frame_size == '0) ? S_RESULT : S_DIV;
              CMD_RELEASE: state <= S_SCAN;
              CMD_QUERY:   state <= S_QUERY;
              default:     state <= S_RESULT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            full      <= div_res.quot;
            need_part <= div_res.rem != '0;
            frag_val  <= frame_size - div_res.rem;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ptr < lim) begin
            ptr       <= ptr + CW'(1);
            chk_valid <= 1'b1;
            chk_addr  <= ptr[AW-1:0];
          end else begin
            chk_valid <= 1'b0;
          end
          if (claim_full) begin
            full <= full - REQ_W'(1);
          end
          if (claim_part) begin
            need_part <= 1'b0;
            last_frag <= frag_val;
          end
          if ((claim_full || claim_part || free_hit) && changed != '1) begin
            changed <= changed + CNT_W'(1);
          end
          if (!chk_valid && ptr >= lim) begin
            state <= S_RESULT;
          end
        end
        S_QUERY: begin
          if (q_hit && rd_busy) begin
            q_busy  <= 1'b1;
            q_owner <= OWNER_W'(rd_owner);
            q_frag  <= rd_frag;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid               <= 1'b1;
            rsp.data.frames_changed <= changed;
            rsp.data.last_frag      <= last_frag;
            rsp.data.shortfall      <= (cur_cmd == CMD_ALLOC) && ((full != '0) || need_part);
            rsp.data.entry_busy     <= q_busy;
            rsp.data.entry_owner    <= q_owner;
            rsp.data.entry_frag     <= q_frag;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) $past(rst) |-> !req.ready)
    else $error("command taken during table clear");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_scan_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_valid) |-> (CW'(chk_addr) + CW'(1)) == ptr)
    else $error("scan check stage out of step with read pointer");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ram_we) |-> CW'(chk_addr) < lim)
    else $error("scan wrote beyond managed frames");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_RESULT)
    else $error("response raised outside result state");
endmodule
